@@ rtl/text_console_cursor_engine_assert.svh @@
// Assertion macros for the text console cursor engine.
// Included by the top level; needs nothing else.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define TCCE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcce: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcce: next-cycle check failed");

`endif

@@ rtl/tcce_pkg.sv @@
// Shared types and constants of the text console cursor engine.
// No dependencies.
`default_nettype none

package tcce_pkg;

    localparam int OP_W    = 2;
    localparam int CFG_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int LOC_OUT_W = 11;

    // Operation codes carried in the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_W-1:0] {
        CFG_TEXT_ATTR = 2'd0,
        CFG_NEWLINE   = 2'd1,
        CFG_BACKSPACE = 2'd2,
        CFG_TAB       = 2'd3
    } cfg_idx_t;

    localparam logic [CHAR_W-1:0] RST_TEXT_ATTR = 8'h0F;
    localparam logic [CHAR_W-1:0] RST_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] RST_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] RST_TAB       = 8'h09;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] CLEAR_ATTR   = 8'h0F;
    localparam logic [CELL_W-1:0] CLEAR_CELL   = {CLEAR_ATTR, 8'h00};
    localparam logic [CELL_W-1:0] SCROLL_FILL  = 16'h0000;

endpackage

`default_nettype wire

@@ rtl/text_console_cursor_engine.sv @@
// Text console cursor engine: a COLUMNS x ROWS character store, a cursor and
// the sequencer that drives them. Uses tcce_pkg, tcce_cell_ram, tcce_index_unit.
//
// One operation is in flight at a time; s_tready is low from acceptance until
// the result beat is taken. Set position, newline, tab and a non-scrolling
// code-less step use the index unit once, for the cursor location; a printable
// character, a backspace and a read use the index unit, one RAM access and the
// index unit again for the cursor location. Clear sweeps the store one cell
// per cycle. A scroll copies the store up one row one cell per cycle through
// the single RAM read and write ports and then zero-fills the bottom row. The
// store is not cleared by reset; clear must be issued before any cell is read.
// The configuration port is always ready.
`default_nettype none

module text_console_cursor_engine #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STEP = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [7:0] character, [15:8] column, [23:16] row
    input  wire logic [23:0]                   s_tdata,
    // [1:0] opcode
    input  wire logic [tcce_pkg::OP_W-1:0]     s_tuser,
    // Result stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [10:0] cursor_location, [18:11] cell_character, [26:19] cell_attribute,
    // [31:27] zero
    output logic      [31:0]                   m_tdata,
    // [0] scrolled
    output logic      [0:0]                    m_tuser,
    // Configuration writes.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tcce_pkg::CFG_W-1:0]    cfg_index,
    input  wire logic [tcce_pkg::CHAR_W-1:0]   cfg_data
);
    import tcce_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int TAB_W  = COL_W + 5;
    localparam int LOC_W  = (ADDR_W > LOC_OUT_W) ? ADDR_W : LOC_OUT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_WRITE,
        S_READ,
        S_SCROLL,
        S_ZERO,
        S_CLEAR,
        S_LOC,
        S_LOAD,
        S_OUT
    } state_t;

    // Sequencer state and registered outputs.
    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [COL_W-1:0]       cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]       cur_row_reg, cur_row_next;
    logic [COL_W-1:0]       tgt_col_reg, tgt_col_next;
    logic [ROW_W-1:0]       tgt_row_reg, tgt_row_next;
    logic [CELL_W-1:0]      wdata_reg, wdata_next;
    logic                   scroll_pend_reg, scroll_pend_next;
    logic                   scrolled_reg, scrolled_next;
    logic [CNT_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic                   copy_pend_reg, copy_pend_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [LOC_OUT_W-1:0]   out_loc_reg, out_loc_next;
    logic                   out_scrolled_reg, out_scrolled_next;
    logic [CHAR_W-1:0]      out_char_reg, out_char_next;
    logic [CHAR_W-1:0]      out_attr_reg, out_attr_next;

    // Configuration registers.
    logic [CHAR_W-1:0]      text_attr_reg;
    logic [CHAR_W-1:0]      newline_reg;
    logic [CHAR_W-1:0]      backspace_reg;
    logic [CHAR_W-1:0]      tab_reg;

    // Input field decode.
    op_t                    in_op;
    logic [CHAR_W-1:0]      in_char;
    logic [CHAR_W-1:0]      in_col;
    logic [CHAR_W-1:0]      in_row;
    logic [COL_W-1:0]       clamp_col;
    logic [ROW_W-1:0]       clamp_row;
    logic [TAB_W-1:0]       tab_sum;
    logic                   s_accept;

    // Shared unit and store connections.
    logic [COL_W-1:0]       idx_col;
    logic [ROW_W-1:0]       idx_row;
    logic [ADDR_W-1:0]      idx;
    logic [LOC_W-1:0]       loc_ext;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [CELL_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [CELL_W-1:0]      ram_rdata;

    assign in_op    = op_t'(s_tuser);
    assign in_char  = s_tdata[7:0];
    assign in_col   = s_tdata[15:8];
    assign in_row   = s_tdata[23:16];
    assign clamp_col = (in_col > CHAR_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1)
                                                       : in_col[COL_W-1:0];
    assign clamp_row = (in_row > CHAR_W'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                    : in_row[ROW_W-1:0];
    assign tab_sum  = TAB_W'(cur_col_reg) + TAB_W'(TAB_STEP);

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign loc_ext  = LOC_W'(idx);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_attr_reg, out_char_reg, out_loc_reg};
    assign m_tuser  = out_scrolled_reg;
    assign cfg_ready = 1'b1;

    // Index unit operands: the cursor when reporting, otherwise the target cell.
    assign idx_col = (state_reg == S_LOC) ? cur_col_reg : tgt_col_reg;
    assign idx_row = (state_reg == S_LOC) ? cur_row_reg : tgt_row_reg;

    tcce_index_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_index (
        .clk (clk),
        .col (idx_col),
        .row (idx_row),
        .idx (idx)
    );

    tcce_cell_ram #(
        .DEPTH (CELLS)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg <= RST_TEXT_ATTR;
            newline_reg   <= RST_NEWLINE;
            backspace_reg <= RST_BACKSPACE;
            tab_reg       <= RST_TAB;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TEXT_ATTR: text_attr_reg <= cfg_data;
                CFG_NEWLINE:   newline_reg   <= cfg_data;
                CFG_BACKSPACE: backspace_reg <= cfg_data;
                CFG_TAB:       tab_reg       <= cfg_data;
                default:       text_attr_reg <= text_attr_reg;
            endcase
        end
    end

    // Store access for each state.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = wr_ptr_reg[ADDR_W-1:0];
        ram_wdata = wdata_reg;
        ram_re    = 1'b0;
        ram_raddr = rd_ptr_reg[ADDR_W-1:0];
        case (state_reg)
            S_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx;
            end
            S_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx;
            end
            S_SCROLL:
            begin
                ram_we    = copy_pend_reg;
                ram_wdata = ram_rdata;
                ram_re    = (rd_ptr_reg != CNT_W'(CELLS));
            end
            S_ZERO:
            begin
                ram_we    = 1'b1;
                ram_wdata = SCROLL_FILL;
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = CLEAR_CELL;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        tgt_col_next      = tgt_col_reg;
        tgt_row_next      = tgt_row_reg;
        wdata_next        = wdata_reg;
        scroll_pend_next  = scroll_pend_reg;
        scrolled_next     = scrolled_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        copy_pend_next    = copy_pend_reg;
        m_tvalid_next     = m_tvalid_reg;
        out_loc_next      = out_loc_reg;
        out_scrolled_next = out_scrolled_reg;
        out_char_next     = out_char_reg;
        out_attr_next     = out_attr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    op_next          = in_op;
                    scroll_pend_next = 1'b0;
                    scrolled_next    = 1'b0;
                    rd_ptr_next      = CNT_W'(COLUMNS);
                    wr_ptr_next      = '0;
                    copy_pend_next   = 1'b0;
                    state_next       = S_LOC;
                    case (in_op)
                        OP_PUT:
                        begin
                            if (in_char == newline_reg)
                            begin
                                // Carriage return plus line feed.
                                cur_col_next = '0;
                                if (cur_row_reg == ROW_W'(ROWS - 1))
                                begin
                                    scrolled_next = 1'b1;
                                    state_next    = S_SCROLL;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                end
                            end
                            else if (in_char == backspace_reg)
                            begin
                                // Step back, then blank the cell under the cursor.
                                if (cur_col_reg != '0)
                                begin
                                    cur_col_next = cur_col_reg - 1'b1;
                                    tgt_col_next = cur_col_reg - 1'b1;
                                    tgt_row_next = cur_row_reg;
                                end
                                else if (cur_row_reg != '0)
                                begin
                                    cur_col_next = COL_W'(COLUMNS - 1);
                                    cur_row_next = cur_row_reg - 1'b1;
                                    tgt_col_next = COL_W'(COLUMNS - 1);
                                    tgt_row_next = cur_row_reg - 1'b1;
                                end
                                else
                                begin
                                    tgt_col_next = cur_col_reg;
                                    tgt_row_next = cur_row_reg;
                                end
                                wdata_next = {text_attr_reg, BLANK_CHAR};
                                state_next = S_ADDR;
                            end
                            else if (in_char == tab_reg)
                            begin
                                // Tab moves only if it stays on the row.
                                if (tab_sum <= TAB_W'(COLUMNS - 1))
                                begin
                                    cur_col_next = tab_sum[COL_W-1:0];
                                end
                            end
                            else
                            begin
                                // Printable: write here, then advance with wrap.
                                tgt_col_next = cur_col_reg;
                                tgt_row_next = cur_row_reg;
                                wdata_next   = {text_attr_reg, in_char};
                                state_next   = S_ADDR;
                                if (cur_col_reg == COL_W'(COLUMNS - 1))
                                begin
                                    cur_col_next = '0;
                                    if (cur_row_reg == ROW_W'(ROWS - 1))
                                    begin
                                        scroll_pend_next = 1'b1;
                                        scrolled_next    = 1'b1;
                                    end
                                    else
                                    begin
                                        cur_row_next = cur_row_reg + 1'b1;
                                    end
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg + 1'b1;
                                end
                            end
                        end
                        OP_SET:
                        begin
                            cur_col_next = clamp_col;
                            cur_row_next = clamp_row;
                        end
                        OP_CLEAR:
                        begin
                            cur_col_next = '0;
                            cur_row_next = '0;
                            state_next   = S_CLEAR;
                        end
                        OP_READ:
                        begin
                            tgt_col_next = clamp_col;
                            tgt_row_next = clamp_row;
                            state_next   = S_ADDR;
                        end
                        default:
                        begin
                            state_next = S_LOC;
                        end
                    endcase
                end
            end
            S_ADDR:
            begin
                // Index unit resolves the target cell address this cycle.
                state_next = (op_reg == OP_READ) ? S_READ : S_WRITE;
            end
            S_WRITE:
            begin
                state_next = scroll_pend_reg ? S_SCROLL : S_LOC;
            end
            S_READ:
            begin
                state_next = S_LOC;
            end
            S_SCROLL:
            begin
                // Read runs one row ahead of write; each read's data arrives in the next cycle.
                if (copy_pend_reg)
                begin
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                if (rd_ptr_reg != CNT_W'(CELLS))
                begin
                    rd_ptr_next    = rd_ptr_reg + 1'b1;
                    copy_pend_next = 1'b1;
                end
                else
                begin
                    copy_pend_next = 1'b0;
                    if (!copy_pend_reg)
                    begin
                        state_next = S_ZERO;
                    end
                end
            end
            S_ZERO:
            begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
                if (wr_ptr_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = S_LOC;
                end
            end
            S_CLEAR:
            begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
                if (wr_ptr_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = S_LOC;
                end
            end
            S_LOC:
            begin
                // Index unit turns the cursor into its linear location.
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                out_loc_next      = loc_ext[LOC_OUT_W-1:0];
                out_scrolled_next = scrolled_reg;
                out_char_next     = (op_reg == OP_READ) ? ram_rdata[7:0] : '0;
                out_attr_next     = (op_reg == OP_READ) ? ram_rdata[15:8] : '0;
                m_tvalid_next     = 1'b1;
                state_next        = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_PUT;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            scroll_pend_reg <= 1'b0;
            scrolled_reg    <= 1'b0;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            copy_pend_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            scroll_pend_reg <= scroll_pend_next;
            scrolled_reg    <= scrolled_next;
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            copy_pend_reg   <= copy_pend_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tgt_col_reg      <= tgt_col_next;
        tgt_row_reg      <= tgt_row_next;
        wdata_reg        <= wdata_next;
        out_loc_reg      <= out_loc_next;
        out_scrolled_reg <= out_scrolled_next;
        out_char_reg     <= out_char_next;
        out_attr_reg     <= out_attr_next;
    end

    // Checks on the sequencer.
`include "text_console_cursor_engine_assert.svh"

    `TCCE_ASSERT_SAME(a_no_accept_while_result, clk, rst_n, m_tvalid, !s_tready)
    `TCCE_ASSERT_SAME(a_cursor_in_range, clk, rst_n, 1'b1,
        (cur_col_reg <= COL_W'(COLUMNS - 1)) && (cur_row_reg <= ROW_W'(ROWS - 1)))
    `TCCE_ASSERT_SAME(a_scroll_on_last_row, clk, rst_n, m_tvalid && m_tuser[0],
        cur_row_reg == ROW_W'(ROWS - 1))
    `TCCE_ASSERT_NEXT(a_clear_sweeps, clk, rst_n,
        s_accept && (in_op == OP_CLEAR), (state_reg == S_CLEAR) && (wr_ptr_reg == '0))

endmodule

`default_nettype wire

@@ rtl/tcce_cell_ram.sv @@
// Cell store: one write port and one read port with registered read data.
// Uses tcce_pkg for the cell width.
`default_nettype none

module tcce_cell_ram #(
    parameter int DEPTH = 2000
) (
    input  wire logic                                 clk,
    input  wire logic                                 wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]             wr_addr,
    input  wire logic [tcce_pkg::CELL_W-1:0]          wr_data,
    input  wire logic                                 rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]             rd_addr,
    output logic      [tcce_pkg::CELL_W-1:0]          rd_data
);
    import tcce_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcce_index_unit.sv @@
// Shared index unit: row times COLUMNS plus column, registered.
// Serves cell addresses and the reported cursor location; no package needed.
`default_nettype none

module tcce_index_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                                  clk,
    input  wire logic [$clog2(COLUMNS)-1:0]            col,
    input  wire logic [$clog2(ROWS)-1:0]               row,
    output logic      [$clog2(COLUMNS*ROWS)-1:0]       idx
);
    localparam int ADDR_W = $clog2(COLUMNS * ROWS);

    logic [ADDR_W-1:0] product;

    // Constant multiply plus add; the result lies below COLUMNS*ROWS when col and row are in range.
    assign product = ADDR_W'(row) * ADDR_W'(COLUMNS);

    always_ff @(posedge clk)
    begin
        idx <= product + ADDR_W'(col);
    end

endmodule

`default_nettype wire
